### rtl/core/sftb_pkg.sv
// Shared types and constants of the syscall filter token bucket unit.
// Used by every module under rtl/core; depends on nothing else.
package sftb_pkg;

    // Field widths
    localparam int CAT_W  = 4;
    localparam int TIME_W = 32;
    localparam int TOK_W  = 16;
    localparam int CNT_W  = 32;

    // Register map: mask at index 0, rate registers after it
    localparam int RATE_REGS  = 6;
    localparam int REG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 32;
    localparam logic [REG_IDX_W-1:0] REG_MASK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RATE0 = 3'd1;

    // Defaults of the top-level parameters
    localparam int DEF_NUM_BUCKETS      = 6;
    localparam int DEF_REFILL_WINDOW_MS = 20;

    // Divide by one second: for elapsed < 1000 ms the product elapsed*rate
    // stays below 2^26, and (p * ceil(2^36/1000)) >> 36 is exact there.
    localparam int               MS_PER_SEC  = 1000;
    localparam int               ELAPSED_W   = 10;
    localparam int               RECIP_SHIFT = 36;
    localparam int               RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP     = 27'd68719477;
    localparam int               SCALE_W     = TOK_W + RECIP_W;
    localparam int               PROD_W      = SCALE_W + ELAPSED_W;

    // Queue between classifier and bucket engine
    localparam int Q_DEPTH = 2;

    localparam int OUT_DATA_W = 120;

    typedef enum logic [1:0] {
        KIND_FREE   = 2'd0,
        KIND_DENIED = 2'd1,
        KIND_BUCKET = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_ALLOW = 2'd0,
        VERDICT_DENY  = 2'd1,
        VERDICT_LIMIT = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [CAT_W-1:0]  category;
        logic [TIME_W-1:0] now_ms;
        t_kind             kind;
    } t_item;

    // Result beat, verdict in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] limited_requests;
        logic [CNT_W-1:0] denied_requests;
        logic [CNT_W-1:0] total_requests;
        logic [TOK_W-1:0] tokens_left;
        t_verdict         verdict;
    } t_result;

    // Register write event handed to the bucket engine
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [TOK_W-1:0]     value;
    } t_cfg_wr;

endpackage

### rtl/core/sftb_queue.sv
// Small FIFO of classified requests between front and back.
// Depends on sftb_pkg.
module sftb_queue
    import sftb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/sftb_front.sv
// Request intake: accepts request beats and sorts them by filter outcome.
// Depends on sftb_pkg; feeds sftb_queue.
module sftb_front
    import sftb_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [TIME_W-1:0] s_axis_tdata,    // [31:0] now_ms
    input  logic [CAT_W-1:0]  s_axis_tuser,    // [3:0] category
    input  logic [TOK_W-1:0]  i_mask,
    input  logic              i_q_full,
    output logic              o_push,
    output t_item             o_item
);

    localparam int NB = (NUM_BUCKETS < RATE_REGS) ? NUM_BUCKETS : RATE_REGS;

    logic has_bucket;
    logic passes;

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    // Classify: filter first, then bucket or free
    always_comb begin
        has_bucket = (32'(s_axis_tuser) < NB);
        passes     = i_mask[s_axis_tuser];
        o_item.category = s_axis_tuser;
        o_item.now_ms   = s_axis_tdata;
        if (!passes) begin
            o_item.kind = KIND_DENIED;
        end else if (has_bucket) begin
            o_item.kind = KIND_BUCKET;
        end else begin
            o_item.kind = KIND_FREE;
        end
    end

endmodule

### rtl/core/sftb_back.sv
// Bucket engine: refills and drains token buckets, keeps the counters,
// and holds the result beat. Depends on sftb_pkg.
module sftb_back
    import sftb_pkg::*;
#(
    parameter int NUM_BUCKETS      = DEF_NUM_BUCKETS,
    parameter int REFILL_WINDOW_MS = DEF_REFILL_WINDOW_MS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_item,
    output logic               o_pop,
    input  t_cfg_wr            i_cfg,
    input  logic [TOK_W-1:0]   i_rate  [RATE_REGS],
    input  logic [SCALE_W-1:0] i_scale [RATE_REGS],
    output logic               o_valid,
    input  logic               i_ready,
    output t_result            o_result
);

    localparam int NB = (NUM_BUCKETS < RATE_REGS) ? NUM_BUCKETS : RATE_REGS;
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;

    logic [TOK_W-1:0]  r_tokens [NB];
    logic [TIME_W-1:0] r_refill [NB];
    logic [CNT_W-1:0]  r_total, r_denied, r_limited;
    logic [CNT_W-1:0]  n_total, n_denied, n_limited;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [BW-1:0]     bidx;
    logic              has_bucket;
    logic [TOK_W-1:0]  tok, rate, refilled, avail, n_tok;
    logic [SCALE_W-1:0] scale;
    logic [TIME_W-1:0] elapsed;
    logic              in_window, full_second;
    logic [PROD_W-1:0] prod;
    logic              bucket_wr, refill_wr;

    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Read the addressed bucket and work out the refill
    always_comb begin
        has_bucket  = (32'(i_item.category) < NB);
        // Park the index on bucket 0 for categories without a bucket
        bidx        = has_bucket ? i_item.category[BW-1:0] : '0;
        tok         = has_bucket ? r_tokens[bidx] : '0;
        rate        = i_rate[bidx];
        scale       = i_scale[bidx];
        elapsed     = i_item.now_ms - r_refill[bidx];
        in_window   = (elapsed >= TIME_W'(REFILL_WINDOW_MS));
        full_second = (elapsed >= TIME_W'(MS_PER_SEC));
        prod        = PROD_W'(elapsed[ELAPSED_W-1:0]) * PROD_W'(scale);
        // An empty bucket plus a full second of gain always caps at the rate
        refilled    = full_second ? rate : prod[RECIP_SHIFT +: TOK_W];
        avail       = (tok == '0 && in_window) ? refilled : tok;
    end

    // Decide verdict, new token count and counters
    always_comb begin
        n_total   = r_total;
        n_denied  = r_denied;
        n_limited = r_limited;
        n_tok     = tok;
        bucket_wr = 1'b0;
        refill_wr = 1'b0;
        n_out.verdict     = VERDICT_ALLOW;
        n_out.tokens_left = '0;
        if (o_pop) begin
            n_total = r_total + CNT_W'(1);
            case (i_item.kind)
                KIND_DENIED: begin
                    n_denied = r_denied + CNT_W'(1);
                    n_out.verdict     = VERDICT_DENY;
                    n_out.tokens_left = tok;
                end
                KIND_BUCKET: begin
                    bucket_wr = 1'b1;
                    refill_wr = (tok == '0) && in_window;
                    if (avail == '0) begin
                        n_limited = r_limited + CNT_W'(1);
                        n_out.verdict = VERDICT_LIMIT;
                        n_tok = '0;
                    end else begin
                        n_tok = avail - TOK_W'(1);
                    end
                    n_out.tokens_left = n_tok;
                end
                default: begin
                    n_out.verdict = VERDICT_ALLOW;
                end
            endcase
        end
        n_out.total_requests   = n_total;
        n_out.denied_requests  = n_denied;
        n_out.limited_requests = n_limited;
    end

    // Bucket state: a rate write reloads the bucket, a request updates it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NB; b++) begin
                r_tokens[b] <= '0;
                r_refill[b] <= '0;
            end
        end else begin
            for (int b = 0; b < NB; b++) begin
                if (i_cfg.en && i_cfg.idx == REG_RATE0 + REG_IDX_W'(b)) begin
                    r_tokens[b] <= i_cfg.value;
                end else if (bucket_wr && bidx == BW'(b)) begin
                    r_tokens[b] <= n_tok;
                end
                if (refill_wr && bidx == BW'(b)) begin
                    r_refill[b] <= i_item.now_ms;
                end
            end
        end
    end

    // Counters and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_denied    <= '0;
            r_limited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_denied  <= n_denied;
            r_limited <= n_limited;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    // Each popped request bumps the total by exactly one
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_total == $past(r_total) + CNT_W'(1))
        else $error("total counter did not advance on a request");

    // A rate-limited result always reports an empty bucket
    a_limit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == VERDICT_LIMIT) |-> r_out.tokens_left == '0)
        else $error("rate-limited result with tokens left");

    // Requests without a bucket that pass the filter are always allowed
    a_free_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.kind == KIND_FREE) |=> r_out.verdict == VERDICT_ALLOW)
        else $error("unlimited request not allowed");

    // A bucket never holds more than its capacity
    for (genvar g = 0; g < NB; g++) begin : g_cap
        a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_tokens[g] <= i_rate[g])
            else $error("bucket above capacity");
    end

endmodule

### rtl/core/syscall_filter_token_bucket_unit.sv
// Top level of the syscall filter token bucket unit: register file,
// intake, queue and bucket engine. Depends on sftb_pkg and rtl/core modules.
//
//  channel   | direction | handshake                | payload
//  s_axis    | in        | tvalid/tready            | tuser category, tdata now_ms
//  m_axis    | out       | tvalid/tready            | tdata verdict..limited counters
//  apb       | in        | psel/penable/pwrite      | paddr, pwdata, prdata
//
// One request per cycle sustained while m_axis_tready keeps up; the bucket
// read-modify-write, refill multiply included, is combinational.
// A request beat is registered in the queue, then in the result register.
// A two-entry queue decouples intake from the result register, so requests
// are still taken while a result waits for m_axis_tready, until it is full.
// Reset is synchronous; all control state clears at once, no clearing pass.
module syscall_filter_token_bucket_unit
    import sftb_pkg::*;
#(
    parameter int NUM_BUCKETS      = DEF_NUM_BUCKETS,
    parameter int REFILL_WINDOW_MS = DEF_REFILL_WINDOW_MS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TIME_W-1:0]     s_axis_tdata,   // [31:0] now_ms
    input  logic [CAT_W-1:0]      s_axis_tuser,   // [3:0] category
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] verdict, [17:2] tokens_left, [49:18] total_requests,
    // [81:50] denied_requests, [113:82] limited_requests, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TOK_W-1:0]   r_mask;
    logic [TOK_W-1:0]   r_rate  [RATE_REGS];
    logic [SCALE_W-1:0] r_scale [RATE_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    t_cfg_wr            cfg;
    logic               push, q_full, q_valid, pop;
    t_item              push_item, head_item;
    t_result            result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_ADDR_W-1:2];

    assign cfg.en    = psel && penable && pwrite && pready;
    assign cfg.idx   = reg_idx;
    assign cfg.value = pwdata[TOK_W-1:0];

    // Register writes; the refill scale is rate times the reciprocal of 1000
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            for (int b = 0; b < RATE_REGS; b++) begin
                r_rate[b]  <= '0;
                r_scale[b] <= '0;
            end
        end else if (cfg.en) begin
            if (cfg.idx == REG_MASK) begin
                r_mask <= cfg.value;
            end
            for (int b = 0; b < RATE_REGS; b++) begin
                if (cfg.idx == REG_RATE0 + REG_IDX_W'(b)) begin
                    r_rate[b]  <= cfg.value;
                    r_scale[b] <= SCALE_W'(cfg.value) * SCALE_W'(RECIP);
                end
            end
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_MASK) begin
            prdata = REG_DATA_W'(r_mask);
        end else begin
            for (int b = 0; b < RATE_REGS; b++) begin
                if (reg_idx == REG_RATE0 + REG_IDX_W'(b)) begin
                    prdata = REG_DATA_W'(r_rate[b]);
                end
            end
        end
    end

    sftb_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_mask        (r_mask),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    sftb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_item)
    );

    sftb_back #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .REFILL_WINDOW_MS (REFILL_WINDOW_MS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (head_item),
        .o_pop     (pop),
        .i_cfg     (cfg),
        .i_rate    (r_rate),
        .i_scale   (r_scale),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = OUT_DATA_W'(result);

endmodule

### tb/syscall_filter_token_bucket_checker.sv
// Scoreboard for the syscall filter token bucket unit: watches request, result and
// register-write traffic, predicts every result beat and compares it field by field.
// Depends on sftb_pkg for widths, register indexes and the result layout.
module syscall_filter_token_bucket_checker
    import sftb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [TIME_W-1:0]     i_req_data,   // [31:0] now_ms
    input  logic [CAT_W-1:0]      i_req_user,   // [3:0] category
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // [1:0] verdict, [17:2] tokens_left, [49:18] total_requests,
    // [81:50] denied_requests, [113:82] limited_requests, rest zero
    input  logic [OUT_DATA_W-1:0] i_res_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [REG_ADDR_W-1:0] i_paddr,
    input  logic [REG_DATA_W-1:0] i_pwdata,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W = $bits(t_result);

    // Shadow copy of the filter and bucket state
    logic [15:0]       pass_mask;
    logic [TOK_W-1:0]  bucket_cap   [RATE_REGS];
    logic [TOK_W-1:0]  bucket_level [RATE_REGS];
    logic [TIME_W-1:0] last_refill  [RATE_REGS];
    logic [CNT_W-1:0]  seen_total;
    logic [CNT_W-1:0]  seen_denied;
    logic [CNT_W-1:0]  seen_limited;
    t_result           verdict_q[$];
    int                mismatches = 0;

    function automatic logic bucketed(input logic [CAT_W-1:0] cat);
        return (int'(cat) < RATE_REGS) && (int'(cat) < DEF_NUM_BUCKETS);
    endfunction

    // Top up an empty bucket once a full refill window has passed
    task automatic top_up(input int b, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       gain;
        logic [63:0]       level;
        elapsed = now - last_refill[b];
        if (elapsed >= TIME_W'(DEF_REFILL_WINDOW_MS)) begin
            last_refill[b] = now;
            gain  = (64'(elapsed) * 64'(bucket_cap[b])) / 64'(MS_PER_SEC);
            level = 64'(bucket_level[b]) + gain;
            if (level > 64'(bucket_cap[b])) begin
                level = 64'(bucket_cap[b]);
            end
            bucket_level[b] = level[TOK_W-1:0];
        end
    endtask

    // Filter one request, spend or refill its bucket, and bump the counters
    task automatic judge_request(input logic [CAT_W-1:0] cat, input logic [TIME_W-1:0] now,
                                 output t_result res);
        int b;
        b   = int'(cat);
        res = '0;
        seen_total++;
        if (!pass_mask[cat]) begin
            seen_denied++;
            res.verdict = VERDICT_DENY;
            if (bucketed(cat)) begin
                res.tokens_left = bucket_level[b];
            end
        end else if (bucketed(cat)) begin
            if (bucket_level[b] == '0) begin
                top_up(b, now);
            end
            if (bucket_level[b] == '0) begin
                seen_limited++;
                res.verdict = VERDICT_LIMIT;
            end else begin
                bucket_level[b]--;
                res.verdict = VERDICT_ALLOW;
            end
            res.tokens_left = bucket_level[b];
        end else begin
            res.verdict = VERDICT_ALLOW;
        end
        res.total_requests   = seen_total;
        res.denied_requests  = seen_denied;
        res.limited_requests = seen_limited;
    endtask

    // Apply a register write; a rate write also fills its bucket
    task automatic load_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [REG_DATA_W-1:0] value);
        int b;
        if (idx == REG_MASK) begin
            pass_mask = value[15:0];
        end else if (idx >= REG_RATE0 && idx < REG_RATE0 + RATE_REGS) begin
            b = int'(idx - REG_RATE0);
            bucket_cap[b]   = value[TOK_W-1:0];
            bucket_level[b] = value[TOK_W-1:0];
        end
    endtask

    always @(posedge i_clk) begin
        t_result predicted;
        t_result expected;
        t_result got;
        logic    bad;
        if (!i_rst_n) begin
            pass_mask    = '0;
            seen_total   = '0;
            seen_denied  = '0;
            seen_limited = '0;
            foreach (bucket_cap[i]) begin
                bucket_cap[i]   = '0;
                bucket_level[i] = '0;
                last_refill[i]  = '0;
            end
            verdict_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                load_register(i_paddr[2 +: REG_IDX_W], i_pwdata);
            end
            if (i_req_valid && i_req_ready) begin
                judge_request(i_req_user, i_req_data, predicted);
                verdict_q.push_back(predicted);
            end
            // Match each result beat against the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got = t_result'(i_res_data[RES_W-1:0]);
                if (verdict_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result beat with no request pending: %h",
                                 $realtime, i_res_data);
                    end
                    mismatches++;
                end else begin
                    expected = verdict_q.pop_front();
                    bad = (got.verdict !== expected.verdict)
                       || (got.tokens_left !== expected.tokens_left)
                       || (got.total_requests !== expected.total_requests)
                       || (got.denied_requests !== expected.denied_requests)
                       || (got.limited_requests !== expected.limited_requests)
                       || (i_res_data[OUT_DATA_W-1:RES_W] !== '0);
                    if (bad) begin
                        if (mismatches < 10) begin
                            $display("%0t: expected verdict %0d tokens %0d cnt %0d/%0d/%0d",
                                     $realtime, expected.verdict, expected.tokens_left,
                                     expected.total_requests, expected.denied_requests,
                                     expected.limited_requests);
                            $display("%0t:      got verdict %0d tokens %0d cnt %0d/%0d/%0d pad %h",
                                     $realtime, got.verdict, got.tokens_left,
                                     got.total_requests, got.denied_requests,
                                     got.limited_requests, i_res_data[OUT_DATA_W-1:RES_W]);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= verdict_q.size();
        o_errors  <= mismatches;
    end

endmodule

### tb/syscall_filter_token_bucket_unit_tb.sv
// Top of the syscall filter token bucket testbench: clock, reset, register setup,
// request stimulus and result back-pressure. Depends on sftb_pkg, the unit under
// test and syscall_filter_token_bucket_checker, which does all result checking.
module syscall_filter_token_bucket_unit_tb
    import sftb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int LIMIT_NS     = 2_000_000;

    // Undecoded register slot past the rate registers
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TIME_W-1:0]     s_axis_tdata = '0;   // [31:0] now_ms
    logic [CAT_W-1:0]      s_axis_tuser = '0;   // [3:0] category
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] verdict, [17:2] tokens_left, [49:18] total_requests,
    // [81:50] denied_requests, [113:82] limited_requests, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [REG_DATA_W-1:0] pwdata = '0;
    logic [REG_DATA_W-1:0] prdata;
    logic                  pready;

    int   errors;
    int   pending;
    logic idle_on = 1'b1;
    logic hold_pending = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    syscall_filter_token_bucket_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    syscall_filter_token_bucket_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Two-phase register write: setup cycle, then access until pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one request beat, hold it until taken, then maybe leave a gap
    task automatic send_req(input logic [CAT_W-1:0] cat, input logic [TIME_W-1:0] now);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cat;
        s_axis_tdata  <= now;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (idle_on && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every outstanding result, then let the pipe drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= !idle_on || ($urandom_range(99) >= 30);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [TIME_W-1:0] clock_ms;
        logic [CAT_W-1:0]  cat;
        logic [TOK_W-1:0]  rate;
        int                roll;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Everything masked off after reset
        send_req(4'd0, 32'd0);
        send_req(4'd9, 32'hFFFF_FFFF);
        settle();

        // Full mask (upper data bits ignored), one rate of each flavor
        write_reg(REG_MASK, 32'hFFFF_FFFF);
        write_reg(REG_RATE0 + 3'd0, 32'd0);
        write_reg(REG_RATE0 + 3'd1, 32'd65535);
        write_reg(REG_RATE0 + 3'd2, 32'hABCD_0003);
        write_reg(REG_RATE0 + 3'd3, 32'd1);
        write_reg(REG_RATE0 + 3'd4, 32'd2);
        write_reg(REG_RATE0 + 3'd5, 32'd1000);
        write_reg(REG_SPARE, 32'h0000_FFFF);

        // Zero rate limits at once; a full bucket just drains
        send_req(4'd0, 32'd100);
        send_req(4'd1, 32'd100);
        // Drain a small bucket, refill with zero gain, too early, then saturate
        repeat (4) send_req(4'd2, 32'd100);
        send_req(4'd2, 32'd110);
        send_req(4'd2, 32'd5000);
        // Product beyond 32 bits, then elapsed time wrapping past zero
        send_req(4'd4, 32'd200);
        send_req(4'd4, 32'd200);
        send_req(4'd4, 32'h8000_0005);
        send_req(4'd4, 32'h8000_0006);
        send_req(4'd4, 32'h0000_0100);
        // Refill with no gain still moves the refill time
        send_req(4'd3, 32'd300);
        send_req(4'd3, 32'd319);
        send_req(4'd3, 32'd2319);
        send_req(4'd5, 32'h7FFF_FFFF);
        // Categories without a bucket
        send_req(4'd6, 32'd0);
        send_req(4'd15, 32'h5555_AAAA);
        settle();

        // Denied requests report the bucket level untouched
        write_reg(REG_MASK, 32'h0000_0004);
        send_req(4'd1, 32'd3000);
        send_req(4'd2, 32'd3000);
        send_req(4'd10, 32'd3000);

        // Random phases, each with its own register setting
        clock_ms = 32'h0000_1000;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            idle_on = (ph != 2);
            roll = $urandom_range(9);
            if (roll == 0) begin
                write_reg(REG_MASK, {16'($urandom), 16'h0000});
            end else if (roll < 4) begin
                write_reg(REG_MASK, {16'($urandom), 16'hFFFF});
            end else begin
                write_reg(REG_MASK, $urandom);
            end
            for (int r = 0; r < RATE_REGS; r++) begin
                if (ph == 0 || $urandom_range(99) < 60) begin
                    roll = $urandom_range(99);
                    if (roll < 10) begin
                        rate = '0;
                    end else if (roll < 20) begin
                        rate = '1;
                    end else if (roll < 30) begin
                        rate = 16'($urandom);
                    end else begin
                        rate = 16'($urandom_range(20, 1));
                    end
                    write_reg(REG_RATE0 + REG_IDX_W'(r), {16'($urandom), rate});
                end
            end
            if ($urandom_range(99) < 20) begin
                write_reg(REG_SPARE, $urandom);
            end
            if (ph == 1) begin
                hold_pending = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) begin
                    settle();
                end
                cat  = ($urandom_range(99) < 80) ? CAT_W'($urandom_range(5))
                                                 : CAT_W'($urandom_range(15));
                roll = $urandom_range(99);
                if (roll < 90) begin
                    clock_ms = clock_ms + $urandom_range(40);
                end else if (roll < 95) begin
                    clock_ms = clock_ms + $urandom_range(100000, 1000);
                end else begin
                    clock_ms = $urandom;
                end
                send_req(cat, clock_ms);
            end
        end

        settle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
